[design/msd_pkg.sv]
`timescale 1ns / 1ps
// Package for the message set deframer: phase encoding, result kinds and
// length-counter sizing. No dependencies.
package msd_pkg;

    // Width of the set length and position counters.
    localparam int LEN_BITS = 31;
    localparam int SET_W    = 31;
    localparam int INV_W    = 31;
    localparam int PAY_W    = 31;

    typedef logic [LEN_BITS-1:0] t_len;

    localparam logic [SET_W-1:0] LEN_MAX =
        SET_W'((64'd1 << LEN_BITS) - 64'd1);
    localparam logic [INV_W-1:0] INV_MAX = '1;

    // Bytes from the start of a record up to the end of its size field.
    localparam logic signed [33:0] REC_HDR_BYTES = 34'sd12;

    localparam logic [3:0] OFFSET_BYTES = 4'd8;
    localparam logic [3:0] WORD_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_KEY       = 3'd1,
        KIND_VALUE     = 3'd2,
        KIND_TRUNC     = 3'd3,
        KIND_MSG_END   = 3'd4
    } t_kind;

    typedef enum logic [10:0] {
        PH_IDLE    = 11'b000_0000_0001,
        PH_OFFSET  = 11'b000_0000_0010,
        PH_SIZE    = 11'b000_0000_0100,
        PH_CRC     = 11'b000_0000_1000,
        PH_MAGIC   = 11'b000_0001_0000,
        PH_ATTR    = 11'b000_0010_0000,
        PH_KEYLEN  = 11'b000_0100_0000,
        PH_KEY     = 11'b000_1000_0000,
        PH_VALLEN  = 11'b001_0000_0000,
        PH_VALUE   = 11'b010_0000_0000,
        PH_SWALLOW = 11'b100_0000_0000
    } t_phase;

endpackage

[design/message_set_deframer.sv]
`timescale 1ns / 1ps
// Message set deframer top level: byte-serial parser of v0 message sets.
// Depends on msd_pkg.
//
// The block takes one byte of a message set per request and, while the result
// side keeps up, accepts a new byte in every cycle. A byte's result request
// passes the input register and then, through the parse logic, the result
// register; a stalled result side can hold the byte in the input register
// between the two. A byte with set start high opens a set of set size
// bytes and is its first byte. Each record yields a header result after its
// attributes byte, then its key and value bytes one per result, or a
// message-end result when the value is empty. A record cut short by the set
// end, or whose size runs past it, gives one truncation report carrying the
// running invalid-byte total; the rest of the set is then swallowed. A byte
// causes at most one result.
module message_set_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_byte_in,
    input  logic                          i_set_start,
    input  logic [msd_pkg::SET_W-1:0]     i_set_size,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_kind,
    output logic signed [63:0]            o_record_offset,
    output logic signed [31:0]            o_message_size,
    output logic [31:0]                   o_crc_word,
    output logic [7:0]                    o_magic,
    output logic [7:0]                    o_attributes,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_last_of_message,
    output logic [msd_pkg::INV_W-1:0]     o_invalid_total
);

    // Input register.
    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_start;
    logic [msd_pkg::SET_W-1:0]  r_in_size;

    // Parser state.
    msd_pkg::t_phase            r_phase, n_phase;
    logic [3:0]                 r_fcnt, n_fcnt;
    logic [63:0]                r_shift, n_shift;
    msd_pkg::t_len              r_consumed, n_consumed;
    msd_pkg::t_len              r_set_len, n_set_len;
    msd_pkg::t_len              r_rec_start, n_rec_start;
    logic [msd_pkg::PAY_W-1:0]  r_left, n_left;
    logic [63:0]                r_off, n_off;
    logic [31:0]                r_size, n_size;
    logic [31:0]                r_crc, n_crc;
    logic [7:0]                 r_magic, n_magic;
    logic [7:0]                 r_attr, n_attr;
    logic [msd_pkg::INV_W-1:0]  r_inv, n_inv;

    // Result register.
    logic                       r_out_valid;
    msd_pkg::t_kind             r_kind, n_kind;
    logic [7:0]                 r_pay, n_pay;
    logic                       r_last, n_last;
    logic                       n_have;
    logic                       r_rep;

    logic out_free;
    logic proc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_comb begin
        logic                      active;
        logic                      at_end;
        logic                      done;
        logic                      rep;
        logic [msd_pkg::SET_W-1:0] sat_len;
        logic signed [33:0]        reach;
        logic                      over;
        logic [31:0]               word;
        logic [msd_pkg::INV_W:0]   inv_sum;
        msd_pkg::t_len             diff;

        n_phase     = r_phase;
        n_fcnt      = r_fcnt;
        n_shift     = r_shift;
        n_consumed  = r_consumed;
        n_set_len   = r_set_len;
        n_rec_start = r_rec_start;
        n_left      = r_left;
        n_off       = r_off;
        n_size      = r_size;
        n_crc       = r_crc;
        n_magic     = r_magic;
        n_attr      = r_attr;
        n_inv       = r_inv;
        n_kind      = msd_pkg::KIND_HEADER;
        n_pay       = '0;
        n_last      = 1'b0;
        n_have      = 1'b0;
        active      = 1'b0;
        at_end      = 1'b0;
        done        = 1'b0;
        rep         = 1'b0;
        sat_len     = '0;
        reach       = '0;
        over        = 1'b0;
        word        = '0;
        inv_sum     = '0;
        diff        = '0;

        if (r_in_start) begin
            sat_len     = (r_in_size > msd_pkg::LEN_MAX) ? msd_pkg::LEN_MAX : r_in_size;
            n_set_len   = msd_pkg::LEN_BITS'(sat_len);
            n_consumed  = '0;
            n_rec_start = '0;
            n_left      = '0;
            n_fcnt      = '0;
            n_shift     = '0;
            n_phase     = (n_set_len == '0) ? msd_pkg::PH_IDLE : msd_pkg::PH_OFFSET;
            active      = (n_set_len != '0);
        end else begin
            active = (r_phase != msd_pkg::PH_IDLE);
        end

        if (active) begin
            n_consumed = n_consumed + 1'b1;
            at_end     = (n_consumed >= n_set_len);
            diff       = n_set_len - n_rec_start;
            inv_sum    = (msd_pkg::INV_W+1)'(r_inv) + (msd_pkg::INV_W+1)'(diff);

            if (n_phase == msd_pkg::PH_SWALLOW) begin
                if (at_end) begin
                    n_phase = msd_pkg::PH_IDLE;
                end
            end else begin
                n_shift = {n_shift[55:0], r_in_byte};
                n_fcnt  = n_fcnt + 4'd1;
                word    = n_shift[31:0];

                unique case (n_phase)
                    msd_pkg::PH_OFFSET: begin
                        if (n_fcnt >= msd_pkg::OFFSET_BYTES) begin
                            n_off   = n_shift;
                            n_phase = msd_pkg::PH_SIZE;
                            n_fcnt  = '0;
                            n_shift = '0;
                        end
                    end
                    msd_pkg::PH_SIZE: begin
                        if (n_fcnt >= msd_pkg::WORD_BYTES) begin
                            n_size  = word;
                            n_phase = msd_pkg::PH_CRC;
                            n_fcnt  = '0;
                            n_shift = '0;
                            reach   = $signed(34'(n_rec_start)) + msd_pkg::REC_HDR_BYTES
                                      + 34'($signed(word));
                            over    = reach > $signed(34'(n_set_len));
                            if (!at_end && over) begin
                                rep     = 1'b1;
                                n_phase = msd_pkg::PH_SWALLOW;
                            end
                        end
                    end
                    msd_pkg::PH_CRC: begin
                        if (n_fcnt >= msd_pkg::WORD_BYTES) begin
                            n_crc   = word;
                            n_phase = msd_pkg::PH_MAGIC;
                            n_fcnt  = '0;
                            n_shift = '0;
                        end
                    end
                    msd_pkg::PH_MAGIC: begin
                        n_magic = r_in_byte;
                        n_phase = msd_pkg::PH_ATTR;
                        n_fcnt  = '0;
                        n_shift = '0;
                    end
                    msd_pkg::PH_ATTR: begin
                        n_attr  = r_in_byte;
                        n_phase = msd_pkg::PH_KEYLEN;
                        n_fcnt  = '0;
                        n_shift = '0;
                        n_kind  = msd_pkg::KIND_HEADER;
                        n_have  = 1'b1;
                    end
                    msd_pkg::PH_KEYLEN: begin
                        if (n_fcnt >= msd_pkg::WORD_BYTES) begin
                            // A negative or zero key length means no key.
                            if (word[31] || word == '0) begin
                                n_phase = msd_pkg::PH_VALLEN;
                            end else begin
                                n_left  = word[msd_pkg::PAY_W-1:0];
                                n_phase = msd_pkg::PH_KEY;
                            end
                            n_fcnt  = '0;
                            n_shift = '0;
                        end
                    end
                    msd_pkg::PH_KEY: begin
                        n_kind  = msd_pkg::KIND_KEY;
                        n_pay   = r_in_byte;
                        n_have  = 1'b1;
                        n_left  = n_left - 1'b1;
                        n_phase = (n_left == '0) ? msd_pkg::PH_VALLEN : msd_pkg::PH_KEY;
                        n_fcnt  = '0;
                        n_shift = '0;
                    end
                    msd_pkg::PH_VALLEN: begin
                        if (n_fcnt >= msd_pkg::WORD_BYTES) begin
                            if (word[31] || word == '0) begin
                                n_kind = msd_pkg::KIND_MSG_END;
                                n_last = 1'b1;
                                n_have = 1'b1;
                                done   = 1'b1;
                            end else begin
                                n_left  = word[msd_pkg::PAY_W-1:0];
                                n_phase = msd_pkg::PH_VALUE;
                                n_fcnt  = '0;
                                n_shift = '0;
                            end
                        end
                    end
                    msd_pkg::PH_VALUE: begin
                        n_left = n_left - 1'b1;
                        n_kind = msd_pkg::KIND_VALUE;
                        n_pay  = r_in_byte;
                        n_last = (n_left == '0);
                        n_have = 1'b1;
                        if (n_left == '0) begin
                            done = 1'b1;
                        end else begin
                            n_fcnt  = '0;
                            n_shift = '0;
                        end
                    end
                    default: begin
                        n_phase = msd_pkg::PH_IDLE;
                    end
                endcase

                if (!rep && done) begin
                    n_fcnt  = '0;
                    n_shift = '0;
                    if (at_end) begin
                        n_phase = msd_pkg::PH_IDLE;
                    end else begin
                        n_rec_start = n_consumed;
                        n_phase     = msd_pkg::PH_OFFSET;
                    end
                end else if (!rep && at_end) begin
                    // The set ended inside this record.
                    rep     = 1'b1;
                    n_phase = msd_pkg::PH_IDLE;
                    n_fcnt  = '0;
                    n_shift = '0;
                end

                if (rep) begin
                    n_inv  = (inv_sum > (msd_pkg::INV_W+1)'(msd_pkg::INV_MAX)) ?
                             msd_pkg::INV_MAX : inv_sum[msd_pkg::INV_W-1:0];
                    n_kind = msd_pkg::KIND_TRUNC;
                    n_pay  = '0;
                    n_last = 1'b0;
                    n_have = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= msd_pkg::PH_IDLE;
            r_fcnt      <= '0;
            r_shift     <= '0;
            r_consumed  <= '0;
            r_set_len   <= '0;
            r_rec_start <= '0;
            r_left      <= '0;
            r_off       <= '0;
            r_size      <= '0;
            r_crc       <= '0;
            r_magic     <= '0;
            r_attr      <= '0;
            r_inv       <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_out_valid <= n_have;
                r_phase     <= n_phase;
                r_fcnt      <= n_fcnt;
                r_shift     <= n_shift;
                r_consumed  <= n_consumed;
                r_set_len   <= n_set_len;
                r_rec_start <= n_rec_start;
                r_left      <= n_left;
                r_off       <= n_off;
                r_size      <= n_size;
                r_crc       <= n_crc;
                r_magic     <= n_magic;
                r_attr      <= n_attr;
                r_inv       <= n_inv;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte  <= i_byte_in;
            r_in_start <= i_set_start;
            r_in_size  <= i_set_size;
        end
        if (proc) begin
            r_kind <= n_kind;
            r_pay  <= n_pay;
            r_last <= n_last;
            r_rep  <= (n_kind == msd_pkg::KIND_TRUNC);
        end
    end

    // Held record fields are read from state; a truncation report zeroes them.
    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_record_offset   = r_rep ? '0 : $signed(r_off);
    assign o_message_size    = r_rep ? '0 : $signed(r_size);
    assign o_crc_word        = r_rep ? '0 : r_crc;
    assign o_magic           = r_rep ? '0 : r_magic;
    assign o_attributes      = r_rep ? '0 : r_attr;
    assign o_payload_byte    = r_pay;
    assign o_last_of_message = r_last;
    assign o_invalid_total   = r_inv;

endmodule
